FILE: hdl/afsc_pkg.sv
// Package for the adaptive frame-skip controller.
// Holds the level, phase and accumulator types, tuning constants and the skip pattern table.
// Used by adaptive_frame_skip_controller; depends on nothing else.
package afsc_pkg;

	localparam int SKIP_LEVELS = 12;
	localparam int LEVEL_W     = 4;
	localparam int PHASE_W     = 4;
	localparam int ACC_W       = 6;

	typedef logic [LEVEL_W-1:0]      level_t;
	typedef logic [PHASE_W-1:0]      phase_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	// Speed thresholds in tenths of a percent
	localparam logic [11:0] SPEED_FAST  = 12'd995;
	localparam logic [11:0] SPEED_SLOW  = 12'd800;
	localparam logic [9:0]  SPEED_BASE  = 10'd900;
	// 1311 / 2^16 approximates 1/50 exactly enough for values up to 900
	localparam logic [10:0] RECIP_50    = 11'd1311;
	localparam int          RECIP_SHIFT = 16;
	localparam level_t      LEVEL_MAX   = level_t'(SKIP_LEVELS - 1);
	localparam level_t      LEVEL_CLOSE = 4'd8;
	localparam logic [31:0] FRAME_MIN   = 32'd24;
	localparam acc_t        ACC_FAST_TOP = 6'sd3;

	// Configuration register indexes
	localparam logic REG_FRAMESKIP = 1'b0;
	localparam logic REG_THROTTLE  = 1'b1;

	// One row per level; bit p set means skip the frame at phase p
	localparam logic [SKIP_LEVELS-1:0] PATTERN_ROM [SKIP_LEVELS] = '{
		12'b000000000000,
		12'b100000000000,
		12'b100000100000,
		12'b100010001000,
		12'b100100100100,
		12'b101001010010,
		12'b101010101010,
		12'b101101011010,
		12'b110110110110,
		12'b111011101110,
		12'b111110111110,
		12'b111111111110
	};

	function automatic logic pattern_bit(level_t lvl, phase_t ph);
		logic result;
		result = 1'b0;
		if ((lvl <= LEVEL_MAX) && (ph <= phase_t'(SKIP_LEVELS - 1))) begin
			result = PATTERN_ROM[lvl][ph];
		end
		return result;
	endfunction

endpackage

FILE: hdl/adaptive_frame_skip_controller.sv
// Adaptive frame-skip controller, top level.
// Input register, single-pass tuning logic and result register; APB register port.
// Depends on afsc_pkg.

// The block takes one item per displayed frame and returns one result item per
// frame: the skip bit for the next frame, the current level, and the auto and
// throttle flags. Items are accepted every clock cycle while the result stream does
// not stall; each item passes an input register and then a result register. The
// level tuning runs in closed form within the cycle the item leaves the input
// register, so the state feedback loop through the level, phase and accumulator
// registers sets the one-item-per-cycle rate while the output does not stall.
// Registers: frameskip_setting at byte 0 (-1 selects auto mode), throttle_setting
// at byte 4. Write them only while no item is in flight.
module adaptive_frame_skip_controller (
	input  logic        clk,
	input  logic        arst_n,
	// Input item stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] bitmap_changed, [1] debug_shown, [13:2] speed_tenths, [45:14] core_frame,
	// [46] paused, [47] inc_pressed, [48] dec_pressed, [49] throttle_pressed
	input  logic [55:0] s_axis_tdata,
	// Result item stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] skip_next, [4:1] skip_level, [5] auto_on, [6] throttle_on
	output logic [7:0]  m_axis_tdata,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import afsc_pkg::*;

	// Input register
	logic        valid_s1;
	logic        drawn_s1;
	logic        dbg_s1;
	logic [11:0] speed_s1;
	logic [31:0] frame_s1;
	logic        pz_s1;
	logic        inc_s1;
	logic        dec_s1;
	logic        thr_s1;

	// Result register
	logic        valid_s2;
	logic        skip_s2;
	level_t      level_s2;
	logic        auto_s2;
	logic        thr_on_s2;

	// Controller state
	level_t      level_q;
	logic        auto_q;
	logic        throttle_q;
	phase_t      phase_q;
	acc_t        acc_q;
	logic        was_paused_q;
	logic        dbg_seen_q;

	logic        advance;
	logic        cfg_wr;

	// Tuning datapath
	logic        was_p;
	logic        tune_en;
	logic        tune_ok;
	logic        fast;
	logic        vslow;
	logic [9:0]  diff;
	logic [20:0] prod;
	acc_t        deficit;
	acc_t        acc_slow;
	acc_t        acc_fast;
	acc_t        acc_neg;
	logic [4:0]  steps;
	logic [4:0]  level_sum;
	level_t      level_tuned;
	acc_t        acc_tuned;
	level_t      level_inc;
	logic        auto_inc;
	level_t      level_dec;
	logic        auto_dec;
	phase_t      phase_next;
	logic        thr_next;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign pready        = 1'b1;
	assign cfg_wr        = psel && penable && pwrite && pready;

	// Tune the level from the measured speed
	always_comb begin
		was_p   = was_paused_q | pz_s1;
		tune_en = drawn_s1 && throttle_q && auto_q && (phase_q == '0);
		tune_ok = tune_en && !was_p && !dbg_seen_q && (frame_s1 > FRAME_MIN);
		fast    = speed_s1 >= SPEED_FAST;
		vslow   = speed_s1 < SPEED_SLOW;
		diff    = SPEED_BASE - speed_s1[9:0];
		prod    = 21'(diff) * 21'(RECIP_50);
		deficit = acc_t'(prod[RECIP_SHIFT +: 5]);

		if (vslow) begin
			acc_slow = acc_q - deficit;
		end else if (level_q < LEVEL_CLOSE) begin
			acc_slow = acc_q - 6'sd1;
		end else begin
			acc_slow = acc_q;
		end
		acc_neg   = -acc_slow;
		acc_fast  = acc_q + 6'sd1;
		steps     = 5'(acc_neg >>> 1);
		level_sum = 5'(level_q) + steps;

		level_tuned = level_q;
		acc_tuned   = acc_q;
		if (tune_ok) begin
			if (fast) begin
				if (acc_fast >= ACC_FAST_TOP) begin
					acc_tuned = '0;
					if (level_q != '0) begin
						level_tuned = level_q - 4'd1;
					end
				end else begin
					acc_tuned = acc_fast;
				end
			end else if (acc_slow <= -6'sd2) begin
				// Each two of deficit raises the level by one
				acc_tuned   = acc_slow[0] ? -6'sd1 : 6'sd0;
				level_tuned = (level_sum > 5'(LEVEL_MAX)) ? LEVEL_MAX : level_sum[3:0];
			end else begin
				acc_tuned = acc_slow;
			end
		end
	end

	// Apply the buttons after tuning and advance the phase
	always_comb begin
		phase_next = (phase_q >= phase_t'(SKIP_LEVELS - 1)) ? '0 : phase_q + 4'd1;

		level_inc = level_tuned;
		auto_inc  = auto_q;
		if (inc_s1) begin
			if (auto_q) begin
				auto_inc  = 1'b0;
				level_inc = '0;
			end else if (level_tuned >= LEVEL_MAX) begin
				auto_inc  = 1'b1;
				level_inc = '0;
			end else begin
				level_inc = level_tuned + 4'd1;
			end
		end

		level_dec = level_inc;
		auto_dec  = auto_inc;
		if (dec_s1) begin
			if (auto_inc) begin
				auto_dec  = 1'b0;
				level_dec = LEVEL_MAX;
			end else if (level_inc == '0) begin
				auto_dec = 1'b1;
			end else begin
				level_dec = level_inc - 4'd1;
			end
		end

		thr_next = throttle_q ^ thr_s1;
	end

	// Capture the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			drawn_s1 <= s_axis_tdata[0];
			dbg_s1   <= s_axis_tdata[1];
			speed_s1 <= s_axis_tdata[13:2];
			frame_s1 <= s_axis_tdata[45:14];
			pz_s1    <= s_axis_tdata[46];
			inc_s1   <= s_axis_tdata[47];
			dec_s1   <= s_axis_tdata[48];
			thr_s1   <= s_axis_tdata[49];
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			skip_s2   <= pattern_bit(level_dec, phase_next);
			level_s2  <= level_dec;
			auto_s2   <= auto_dec;
			thr_on_s2 <= thr_next;
		end
	end

	// Update state on each item or register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			auto_q       <= 1'b1;
			throttle_q   <= 1'b1;
			phase_q      <= '0;
			acc_q        <= '0;
			was_paused_q <= 1'b0;
			dbg_seen_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FRAMESKIP: begin
					if (pwdata[4]) begin
						level_q <= '0;
						auto_q  <= 1'b1;
					end else begin
						level_q <= (pwdata[3:0] > LEVEL_MAX) ? LEVEL_MAX : pwdata[3:0];
						auto_q  <= 1'b0;
					end
				end
				REG_THROTTLE: begin
					throttle_q <= pwdata[0];
				end
			endcase
		end else if (advance) begin
			level_q    <= level_dec;
			auto_q     <= auto_dec;
			throttle_q <= thr_next;
			phase_q    <= phase_next;
			acc_q      <= acc_tuned;
			// A tuning entry rearms the pause and debugger guards
			was_paused_q <= tune_en ? pz_s1 : was_p;
			dbg_seen_q   <= dbg_s1 | (dbg_seen_q & !tune_en);
		end
	end

	// Register readback
	always_comb begin
		unique case (paddr[2])
			REG_FRAMESKIP: prdata = auto_q ? '1 : 32'(level_q);
			REG_THROTTLE:  prdata = 32'(throttle_q);
		endcase
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, thr_on_s2, auto_s2, level_s2, skip_s2};

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LEVEL_MAX) else $error("level out of range");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= phase_t'(SKIP_LEVELS - 1)) else $error("phase out of range");
	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q >= -6'sd1) && (acc_q <= 6'sd2)) else $error("accumulator out of range");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid) else $error("result not registered");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready) else $error("input stalled while empty");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_frame_skip_controller.
// Holds a scoreboard class with its own frame-skip predictor; depends on afsc_pkg and the RTL.

// One displayed frame as offered on the input stream
typedef struct {
	bit        drawn;
	bit        dbg;
	bit [11:0] speed;
	bit [31:0] core_frame;
	bit        paused;
	bit        inc;
	bit        dec;
	bit        thr;
} frame_t;

// One expected result item
typedef struct {
	bit       skip;
	bit [3:0] level;
	bit       auto_on;
	bit       thr_on;
} skip_result_t;

// Tuning thresholds, speed in tenths of a percent
localparam int FAST_TENTHS   = 995;
localparam int SLOW_TENTHS   = 800;
localparam int BASE_TENTHS   = 900;
localparam int STEP_TENTHS   = 50;
localparam int CLOSE_LEVEL   = 8;
localparam int TOP_LEVEL     = 11;
localparam int PHASE_COUNT   = 12;
localparam int FAST_RUN      = 3;
localparam int MIN_TUNE_FRAME = 24;

class skip_scoreboard;
	int           level;
	int           phase;
	int           acc;
	bit           auto_mode;
	bit           thr_flag;
	bit           was_paused;
	bit           is_paused;
	bit           dbg_seen;
	bit [11:0]    skip_rows [PHASE_COUNT];
	skip_result_t pending_skips [$];
	int           errors;
	int           checked;

	function new();
		level      = 0;
		phase      = 0;
		acc        = 0;
		auto_mode  = 1'b1;
		thr_flag   = 1'b1;
		was_paused = 1'b0;
		is_paused  = 1'b0;
		dbg_seen   = 1'b0;
		errors     = 0;
		checked    = 0;
		// Bit p of row l: skip the frame at phase p when at level l
		skip_rows = '{
			12'b000000000000, 12'b100000000000, 12'b100000100000, 12'b100010001000,
			12'b100100100100, 12'b101001010010, 12'b101010101010, 12'b101101011010,
			12'b110110110110, 12'b111011101110, 12'b111110111110, 12'b111111111110
		};
	endfunction

	// Mirror a register write
	function void apply_setting(logic index, logic [31:0] value);
		bit [4:0] v;
		v = value[4:0];
		if (index == afsc_pkg::REG_FRAMESKIP) begin
			if (v[4]) begin
				level     = 0;
				auto_mode = 1'b1;
			end else begin
				level     = (v > TOP_LEVEL) ? TOP_LEVEL : int'(v);
				auto_mode = 1'b0;
			end
		end else begin
			thr_flag = value[0];
		end
	endfunction

	// Advance the predicted state by one accepted frame and queue its result
	function void note_frame(frame_t f);
		int           spd;
		skip_result_t want;
		spd = f.speed;
		is_paused = f.paused;
		if (f.paused)
			was_paused = 1'b1;
		// Tuning entry at phase 0
		if (f.drawn && thr_flag && auto_mode && phase == 0) begin
			if (!was_paused && !dbg_seen && f.core_frame > MIN_TUNE_FRAME) begin
				if (spd >= FAST_TENTHS) begin
					acc++;
					if (acc >= FAST_RUN) begin
						acc = 0;
						if (level > 0)
							level--;
					end
				end else begin
					if (spd < SLOW_TENTHS)
						acc -= (BASE_TENTHS - spd) / STEP_TENTHS;
					else if (level < CLOSE_LEVEL)
						acc--;
					while (acc <= -2) begin
						acc += 2;
						if (level < TOP_LEVEL)
							level++;
					end
				end
			end
			was_paused = is_paused;
			dbg_seen   = 1'b0;
		end
		if (f.dbg)
			dbg_seen = 1'b1;
		phase = (phase + 1) % PHASE_COUNT;
		// Buttons act last
		if (f.inc) begin
			if (auto_mode) begin
				auto_mode = 1'b0;
				level     = 0;
			end else if (level >= TOP_LEVEL) begin
				level     = 0;
				auto_mode = 1'b1;
			end else begin
				level++;
			end
		end
		if (f.dec) begin
			if (auto_mode) begin
				auto_mode = 1'b0;
				level     = TOP_LEVEL;
			end else if (level == 0) begin
				auto_mode = 1'b1;
			end else begin
				level--;
			end
		end
		if (f.thr)
			thr_flag = !thr_flag;
		want.skip    = skip_rows[level][phase];
		want.level   = level[3:0];
		want.auto_on = auto_mode;
		want.thr_on  = thr_flag;
		pending_skips.push_back(want);
	endfunction

	task report(string msg);
		$display("result %0d: %s", checked, msg);
		errors++;
	endtask

	// Compare one accepted result item with the oldest expectation
	task check_result(logic [7:0] data);
		skip_result_t want;
		if (pending_skips.size() == 0) begin
			report($sformatf("unexpected result item %h", data));
		end else begin
			want = pending_skips.pop_front();
			if (data[0] !== want.skip)
				report($sformatf("skip_next: got %b, expected %b", data[0], want.skip));
			if (data[4:1] !== want.level)
				report($sformatf("skip_level: got %0d, expected %0d", data[4:1], want.level));
			if (data[5] !== want.auto_on)
				report($sformatf("auto_on: got %b, expected %b", data[5], want.auto_on));
			if (data[6] !== want.thr_on)
				report($sformatf("throttle_on: got %b, expected %b", data[6], want.thr_on));
		end
		checked++;
	endtask
endclass

module testbench;

	localparam logic [2:0] ADDR_FRAMESKIP = {afsc_pkg::REG_FRAMESKIP, 2'b00};
	localparam logic [2:0] ADDR_THROTTLE  = {afsc_pkg::REG_THROTTLE, 2'b00};
	localparam int         HOLD_CYCLES    = 300;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [2:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;

	skip_scoreboard sb = new();
	bit src_quiet  = 1'b0;
	bit sink_quiet = 1'b0;
	bit hold_req   = 1'b0;

	adaptive_frame_skip_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #5 clk = ~clk;

	// Offer one frame after a random gap; valid stays high when no gap follows
	task send_frame(input frame_t f);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {6'b0, f.thr, f.dec, f.inc, f.paused, f.core_frame, f.speed,
			f.dbg, f.drawn};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_frame(f);
	endtask

	task send_fields(input bit drawn, input bit dbg, input bit [11:0] speed,
		input bit [31:0] core_frame, input bit paused, input bit inc, input bit dec,
		input bit thr);
		frame_t f;
		f.drawn      = drawn;
		f.dbg        = dbg;
		f.speed      = speed;
		f.core_frame = core_frame;
		f.paused     = paused;
		f.inc        = inc;
		f.dec        = dec;
		f.thr        = thr;
		send_frame(f);
	endtask

	// Setup phase, then access phase until pready
	task write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.apply_setting(addr[2], data);
	endtask

	// Drop valid and hold until every result has come back
	task wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_skips.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result sink with random stalls and one long hold-off
	initial begin : result_sink
		int stall;
		int taken;
		taken = 0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_req) begin
				stall    = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (sink_quiet) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 19);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata);
			taken++;
			if (taken % 40 == 0)
				sink_quiet = ($urandom_range(0, 3) == 0);
		end
	end

	// Stimulus
	initial begin : stimulus
		frame_t      f;
		int          r;
		int          fast_pct;
		logic [31:0] fs_val;
		logic [31:0] thr_val;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames; the phase starts at 0 after reset
		send_fields(1, 0, 12'd0,    32'd25,         0, 0, 0, 0); // very slow tune
		send_fields(1, 1, 12'd4095, 32'hFFFF_FFFF,  0, 0, 0, 0); // debugger frame
		send_fields(1, 0, 12'd995,  32'd0,          1, 0, 0, 0); // paused
		send_fields(1, 0, 12'd994,  32'd24,         0, 0, 0, 0);
		send_fields(1, 0, 12'd800,  32'd25,         0, 0, 0, 1); // throttle off
		send_fields(0, 0, 12'd799,  32'd26,         0, 0, 0, 1); // throttle on
		send_fields(1, 0, 12'd100,  32'h8000_0000,  0, 0, 0, 0);
		send_fields(1, 0, 12'd2048, 32'h7FFF_FFFF,  0, 0, 0, 0);
		send_fields(0, 0, 12'd1,    32'd1,          0, 0, 0, 0);
		send_fields(1, 0, 12'd999,  32'd1000,       0, 0, 0, 0);
		send_fields(1, 0, 12'd850,  32'd2000,       0, 0, 0, 0);
		send_fields(1, 0, 12'd800,  32'd3000,       0, 0, 0, 0);
		send_fields(1, 0, 12'd0,    32'd100,        0, 0, 0, 0); // tuning blocked
		send_fields(1, 0, 12'd500,  32'd101,        0, 1, 0, 0); // inc in auto
		send_fields(1, 0, 12'd500,  32'd102,        0, 0, 1, 0); // dec at 0
		send_fields(1, 0, 12'd500,  32'd103,        0, 0, 1, 0); // dec in auto
		send_fields(1, 0, 12'd500,  32'd104,        0, 1, 0, 0); // inc at top
		send_fields(1, 0, 12'd500,  32'd105,        0, 1, 1, 0); // inc then dec
		send_fields(1, 0, 12'd3000, 32'd106,        0, 0, 0, 0);
		send_fields(1, 0, 12'd3000, 32'd107,        0, 0, 0, 0);
		send_fields(1, 0, 12'd3000, 32'd108,        0, 0, 0, 0);
		send_fields(1, 0, 12'd3000, 32'd109,        0, 0, 0, 0);
		send_fields(1, 0, 12'd3000, 32'd110,        0, 0, 0, 0);
		send_fields(1, 0, 12'd3000, 32'd111,        0, 0, 0, 0);
		send_fields(1, 0, 12'd995,  32'd112,        0, 0, 0, 0); // fast tune
		wait_idle();

		// Random phases, each under its own register settings
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin fs_val = 32'd15;        thr_val = 32'd1; end
				1: begin fs_val = 32'hFFFF_FFFF; thr_val = 32'd1; end
				2: begin fs_val = 32'h10;        thr_val = 32'd1; end
				3: begin fs_val = 32'd0;         thr_val = 32'd0; end
				4: begin fs_val = 32'hFFFF_FFFF; thr_val = 32'hFFFF_FFFF; end
				5: begin fs_val = 32'd11;        thr_val = 32'd1; end
				6: begin fs_val = 32'hFFFF_FFFF; thr_val = 32'd1; end
				7: begin fs_val = 32'd12;        thr_val = 32'hFFFF_FFFE; end
				8: begin fs_val = 32'hFFFF_FFFF; thr_val = 32'd1; end
				default: begin fs_val = $urandom; thr_val = $urandom; end
			endcase
			write_reg(ADDR_FRAMESKIP, fs_val);
			write_reg(ADDR_THROTTLE, thr_val);
			src_quiet = (ph == 3) || (ph % 4 == 1);
			fast_pct  = (ph % 2 == 0) ? 65 : 25;
			for (int n = 0; n < 40; n++) begin
				if (ph == 3 && n == 5)
					hold_req = 1'b1;
				if ($urandom_range(0, 99) < 15) begin
					// Noise: every field fully random
					f.drawn      = 1'($urandom);
					f.dbg        = 1'($urandom);
					f.speed      = 12'($urandom);
					f.core_frame = $urandom;
					f.paused     = 1'($urandom);
					f.inc        = 1'($urandom);
					f.dec        = 1'($urandom);
					f.thr        = 1'($urandom);
				end else begin
					f.drawn      = ($urandom_range(0, 9) != 0);
					f.dbg        = ($urandom_range(0, 9) == 0);
					f.paused     = ($urandom_range(0, 11) == 0);
					f.core_frame = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom;
					r = $urandom_range(0, 99);
					if (r < fast_pct)
						f.speed = 12'($urandom_range(995, 4095));
					else if (r < fast_pct + 15)
						f.speed = 12'($urandom_range(800, 994));
					else
						f.speed = 12'($urandom_range(0, 799));
					f.inc = ($urandom_range(0, 29) == 0);
					f.dec = ($urandom_range(0, 29) == 0);
					f.thr = ($urandom_range(0, 39) == 0);
				end
				send_frame(f);
			end
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[adaptive_frame_skip_controller] OK");
		end else begin
			$display("[adaptive_frame_skip_controller] ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#5_000_000;
		$display("[adaptive_frame_skip_controller] ERROR");
		$finish;
	end

endmodule
